// ===== design/bpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfm_pkg
// Shared types and constants for the battery pack fault monitor.
// ----------------------------------------------------------------------------
package bpfm_pkg;

   // cell and measurement widths
   localparam int unsigned TapWidth  = 15;
   localparam int unsigned CellWidth = 16;
   localparam int unsigned MeasWidth = 16;
   localparam int unsigned CsrWidth  = 16;
   localparam int unsigned NumCells  = 4;
   localparam int unsigned CsrIdxW   = 3;

   // fault codes, also the result encoding
   typedef enum logic [2:0] {
      FAULT_NONE = 3'd0,
      FAULT_UV   = 3'd1,
      FAULT_OV   = 3'd2,
      FAULT_OC   = 3'd3,
      FAULT_OT   = 3'd4
   } fault_type;

   // register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_UV_TRIP    = 3'd0,
      CSR_UV_RELEASE = 3'd1,
      CSR_OV_TRIP    = 3'd2,
      CSR_OV_RELEASE = 3'd3,
      CSR_OC_TRIP    = 3'd4,
      CSR_OC_RELEASE = 3'd5,
      CSR_OT_TRIP    = 3'd6,
      CSR_OT_RELEASE = 3'd7
   } csr_index_type;

   // threshold register set
   typedef struct packed {
      logic        [TapWidth-1:0]  uv_trip;
      logic        [TapWidth-1:0]  uv_release;
      logic        [TapWidth-1:0]  ov_trip;
      logic        [TapWidth-1:0]  ov_release;
      logic        [TapWidth-1:0]  oc_trip;
      logic        [TapWidth-1:0]  oc_release;
      logic signed [MeasWidth-1:0] ot_trip;
      logic signed [MeasWidth-1:0] ot_release;
   } cfg_type;

   // reset values of the thresholds
   localparam cfg_type CfgReset = '{
      uv_trip:    15'd3000,
      uv_release: 15'd3050,
      ov_trip:    15'd4250,
      ov_release: 15'd4150,
      oc_trip:    15'd15000,
      oc_release: 15'd2000,
      ot_trip:    16'sd5500,
      ot_release: 16'sd4500
   };

   // per-lane findings handed to the merge stage
   typedef struct packed {
      logic uv_trip;
      logic ov_trip;
      logic uv_clear;
      logic ov_clear;
   } lane_flags_type;

endpackage

// ===== design/battery_pack_fault_monitor.sv =====
// An accepted request's response appears in the output register in the next cycle.
// One transaction per cycle unless stalled; four cell lanes and the merge are combinational.
// The request side stalls only while a response is held and rsp_stall is high.
// Reset (synchronous, active high) clears the fault state to no fault, empties the
// output register and loads the default thresholds.
// ----------------------------------------------------------------------------
// battery_pack_fault_monitor
// Four-cell protection monitor with per-fault hysteresis and relay enable.
// ----------------------------------------------------------------------------
module battery_pack_fault_monitor (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_we,
   input  logic [bpfm_pkg::CsrIdxW-1:0]           csr_index,
   input  logic [bpfm_pkg::CsrWidth-1:0]          csr_wdata,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_tap1_mv,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_tap2_mv,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_tap3_mv,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_tap4_mv,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_cell1_offset_mv,
   input  logic signed [bpfm_pkg::MeasWidth-1:0]  req_current_ma,
   input  logic signed [bpfm_pkg::MeasWidth-1:0]  req_temp_centi,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [2:0]                             rsp_fault,
   output logic                                   rsp_relay_closed,
   output logic [bpfm_pkg::TapWidth-1:0]          rsp_cell1_mv,
   output logic signed [bpfm_pkg::CellWidth-1:0]  rsp_cell2_mv,
   output logic signed [bpfm_pkg::CellWidth-1:0]  rsp_cell3_mv,
   output logic signed [bpfm_pkg::CellWidth-1:0]  rsp_cell4_mv
);

   bpfm_pkg::cfg_type        cfg_ff;
   bpfm_pkg::cfg_type        cfg_in;
   bpfm_pkg::fault_type      fault_ff;
   bpfm_pkg::fault_type      fault_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     req_accept;
   logic [bpfm_pkg::TapWidth-1:0]         lane_hi [bpfm_pkg::NumCells];
   logic [bpfm_pkg::TapWidth-1:0]         lane_lo [bpfm_pkg::NumCells];
   logic signed [bpfm_pkg::CellWidth-1:0] lane_cell [bpfm_pkg::NumCells];
   bpfm_pkg::lane_flags_type              lane_flags [bpfm_pkg::NumCells];
   logic signed [bpfm_pkg::CellWidth-1:0] cell_ff [bpfm_pkg::NumCells];

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (bpfm_pkg::csr_index_type'(csr_index))
            bpfm_pkg::CSR_UV_TRIP:    cfg_in.uv_trip    = csr_wdata[bpfm_pkg::TapWidth-1:0];
            bpfm_pkg::CSR_UV_RELEASE: cfg_in.uv_release = csr_wdata[bpfm_pkg::TapWidth-1:0];
            bpfm_pkg::CSR_OV_TRIP:    cfg_in.ov_trip    = csr_wdata[bpfm_pkg::TapWidth-1:0];
            bpfm_pkg::CSR_OV_RELEASE: cfg_in.ov_release = csr_wdata[bpfm_pkg::TapWidth-1:0];
            bpfm_pkg::CSR_OC_TRIP:    cfg_in.oc_trip    = csr_wdata[bpfm_pkg::TapWidth-1:0];
            bpfm_pkg::CSR_OC_RELEASE: cfg_in.oc_release = csr_wdata[bpfm_pkg::TapWidth-1:0];
            bpfm_pkg::CSR_OT_TRIP:    cfg_in.ot_trip    = $signed(csr_wdata);
            bpfm_pkg::CSR_OT_RELEASE: cfg_in.ot_release = $signed(csr_wdata);
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   // handshake: output register frees when taken
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign req_accept   = req_valid & ~req_stall;
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   // lane operands: bottom cell uses the offset and clamps
   assign lane_hi[0] = req_tap1_mv;
   assign lane_lo[0] = req_cell1_offset_mv;
   assign lane_hi[1] = req_tap2_mv;
   assign lane_lo[1] = req_tap1_mv;
   assign lane_hi[2] = req_tap3_mv;
   assign lane_lo[2] = req_tap2_mv;
   assign lane_hi[3] = req_tap4_mv;
   assign lane_lo[3] = req_tap3_mv;

   // cell lanes
   for (genvar g = 0; g < bpfm_pkg::NumCells; g++) begin : g_lane
      bpfm_cell_lane u_lane (
         .tap_hi     (lane_hi[g]),
         .tap_lo     (lane_lo[g]),
         .clamp_zero (g == 0),
         .cfg        (cfg_ff),
         .cell_mv    (lane_cell[g]),
         .flags      (lane_flags[g])
      );
   end

   // merge lanes into the fault state
   bpfm_fault_merge u_merge (
      .lane_flags (lane_flags),
      .current_ma (req_current_ma),
      .temp_centi (req_temp_centi),
      .cfg        (cfg_ff),
      .fault_cur  (fault_ff),
      .fault_next (fault_in)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= bpfm_pkg::CfgReset;
         fault_ff     <= bpfm_pkg::FAULT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) fault_ff <= fault_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < bpfm_pkg::NumCells; i++) cell_ff[i] <= lane_cell[i];
      end
   end

   // outputs; the fault register holds the last accepted result
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fault        = fault_ff;
   assign rsp_relay_closed = (fault_ff == bpfm_pkg::FAULT_NONE);
   assign rsp_cell1_mv     = cell_ff[0][bpfm_pkg::TapWidth-1:0];
   assign rsp_cell2_mv     = cell_ff[1];
   assign rsp_cell3_mv     = cell_ff[2];
   assign rsp_cell4_mv     = cell_ff[3];

endmodule

// ===== design/bpfm_cell_lane.sv =====
// ----------------------------------------------------------------------------
// bpfm_cell_lane
// One cell lane: tap difference, optional clamp at zero, threshold compares.
// ----------------------------------------------------------------------------
module bpfm_cell_lane (
   input  logic [bpfm_pkg::TapWidth-1:0]          tap_hi,
   input  logic [bpfm_pkg::TapWidth-1:0]          tap_lo,
   input  logic                                   clamp_zero,
   input  bpfm_pkg::cfg_type                      cfg,
   output logic signed [bpfm_pkg::CellWidth-1:0]  cell_mv,
   output bpfm_pkg::lane_flags_type               flags
);

   logic signed [bpfm_pkg::CellWidth:0] diff;
   logic signed [bpfm_pkg::CellWidth:0] cell_ext;
   logic signed [bpfm_pkg::CellWidth:0] uv_trip_ext;
   logic signed [bpfm_pkg::CellWidth:0] uv_rel_ext;
   logic signed [bpfm_pkg::CellWidth:0] ov_trip_ext;
   logic signed [bpfm_pkg::CellWidth:0] ov_rel_ext;

   // signed difference of the two taps
   assign diff = $signed({2'b00, tap_hi}) - $signed({2'b00, tap_lo});

   // clamp for the bottom cell
   assign cell_ext = (clamp_zero && diff[bpfm_pkg::CellWidth]) ? '0 : diff;
   assign cell_mv  = cell_ext[bpfm_pkg::CellWidth-1:0];

   // thresholds widened to the cell range
   assign uv_trip_ext = $signed({2'b00, cfg.uv_trip});
   assign uv_rel_ext  = $signed({2'b00, cfg.uv_release});
   assign ov_trip_ext = $signed({2'b00, cfg.ov_trip});
   assign ov_rel_ext  = $signed({2'b00, cfg.ov_release});

   // trip and release compares
   assign flags.uv_trip  = cell_ext < uv_trip_ext;
   assign flags.ov_trip  = cell_ext > ov_trip_ext;
   assign flags.uv_clear = cell_ext > uv_rel_ext;
   assign flags.ov_clear = cell_ext < ov_rel_ext;

endmodule

// ===== design/bpfm_fault_merge.sv =====
// ----------------------------------------------------------------------------
// bpfm_fault_merge
// Combines lane findings with current and temperature checks into the next
// fault state: priority trip first, then release of the held fault.
// ----------------------------------------------------------------------------
module bpfm_fault_merge (
   input  bpfm_pkg::lane_flags_type               lane_flags [bpfm_pkg::NumCells],
   input  logic signed [bpfm_pkg::MeasWidth-1:0]  current_ma,
   input  logic signed [bpfm_pkg::MeasWidth-1:0]  temp_centi,
   input  bpfm_pkg::cfg_type                      cfg,
   input  bpfm_pkg::fault_type                    fault_cur,
   output bpfm_pkg::fault_type                    fault_next
);

   logic any_uv;
   logic any_ov;
   logic all_uv_clear;
   logic all_ov_clear;
   logic oc_trip;
   logic oc_clear;
   logic ot_trip;
   logic ot_clear;
   logic signed [bpfm_pkg::MeasWidth:0] cur_ext;
   logic signed [bpfm_pkg::MeasWidth:0] oc_trip_pos;
   logic signed [bpfm_pkg::MeasWidth:0] oc_trip_neg;
   logic signed [bpfm_pkg::MeasWidth:0] oc_rel_pos;
   logic signed [bpfm_pkg::MeasWidth:0] oc_rel_neg;
   bpfm_pkg::fault_type tripped;

   // reduce lane findings
   always_comb begin
      any_uv       = 1'b0;
      any_ov       = 1'b0;
      all_uv_clear = 1'b1;
      all_ov_clear = 1'b1;
      for (int i = 0; i < bpfm_pkg::NumCells; i++) begin
         any_uv       = any_uv | lane_flags[i].uv_trip;
         any_ov       = any_ov | lane_flags[i].ov_trip;
         all_uv_clear = all_uv_clear & lane_flags[i].uv_clear;
         all_ov_clear = all_ov_clear & lane_flags[i].ov_clear;
      end
   end

   // current magnitude window
   assign cur_ext     = {current_ma[bpfm_pkg::MeasWidth-1], current_ma};
   assign oc_trip_pos = $signed({2'b00, cfg.oc_trip});
   assign oc_trip_neg = -oc_trip_pos;
   assign oc_rel_pos  = $signed({2'b00, cfg.oc_release});
   assign oc_rel_neg  = -oc_rel_pos;
   assign oc_trip     = (cur_ext > oc_trip_pos) || (cur_ext < oc_trip_neg);
   assign oc_clear    = (cur_ext > oc_rel_neg) && (cur_ext < oc_rel_pos);

   // temperature compares
   assign ot_trip  = temp_centi > cfg.ot_trip;
   assign ot_clear = temp_centi < cfg.ot_release;

   // priority trip overwrites the held fault
   always_comb begin
      if (any_uv)       tripped = bpfm_pkg::FAULT_UV;
      else if (any_ov)  tripped = bpfm_pkg::FAULT_OV;
      else if (oc_trip) tripped = bpfm_pkg::FAULT_OC;
      else if (ot_trip) tripped = bpfm_pkg::FAULT_OT;
      else              tripped = fault_cur;
   end

   // release of whichever fault is now held
   always_comb begin
      fault_next = tripped;
      case (tripped)
         bpfm_pkg::FAULT_UV: if (all_uv_clear) fault_next = bpfm_pkg::FAULT_NONE;
         bpfm_pkg::FAULT_OV: if (all_ov_clear) fault_next = bpfm_pkg::FAULT_NONE;
         bpfm_pkg::FAULT_OC: if (oc_clear)     fault_next = bpfm_pkg::FAULT_NONE;
         bpfm_pkg::FAULT_OT: if (ot_clear)     fault_next = bpfm_pkg::FAULT_NONE;
         default:            fault_next = tripped;
      endcase
   end

endmodule

// ===== design/bpfm_checker.sv =====
// ----------------------------------------------------------------------------
// bpfm_port_props
// Port-level checks on the battery pack fault monitor, bound to the top level.
// ----------------------------------------------------------------------------
module bpfm_port_props (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [2:0]                             rsp_fault,
   input  logic                                   rsp_relay_closed
);

   // relay follows the fault code
   a_relay_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_relay_closed == (rsp_fault == 3'd0)))
      else $error("relay enable disagrees with fault code");

   // only defined fault codes appear
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fault <= 3'd4))
      else $error("undefined fault code");

   // an accepted transaction shows a response next cycle
   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted transaction produced no response");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // held response keeps its fault code
   a_hold_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_fault)))
      else $error("stalled response changed");

endmodule

bind battery_pack_fault_monitor bpfm_port_props u_bpfm_port_props (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_fault        (rsp_fault),
   .rsp_relay_closed (rsp_relay_closed)
);

// ===== tb/bpfm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_checker
// Passive checker for the battery pack fault monitor. Follows threshold writes
// and accepted measurement transactions, predicts each response from its own
// copy of the thresholds and the held fault, and compares every accepted
// response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bpfm_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [bpfm_pkg::CsrIdxW-1:0]           csr_index,
   input  logic [bpfm_pkg::CsrWidth-1:0]          csr_wdata,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_tap1_mv,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_tap2_mv,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_tap3_mv,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_tap4_mv,
   input  logic [bpfm_pkg::TapWidth-1:0]          req_cell1_offset_mv,
   input  logic signed [bpfm_pkg::MeasWidth-1:0]  req_current_ma,
   input  logic signed [bpfm_pkg::MeasWidth-1:0]  req_temp_centi,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [2:0]                             rsp_fault,
   input  logic                                   rsp_relay_closed,
   input  logic [bpfm_pkg::TapWidth-1:0]          rsp_cell1_mv,
   input  logic signed [bpfm_pkg::CellWidth-1:0]  rsp_cell2_mv,
   input  logic signed [bpfm_pkg::CellWidth-1:0]  rsp_cell3_mv,
   input  logic signed [bpfm_pkg::CellWidth-1:0]  rsp_cell4_mv,
   output int                                     errors,
   output int                                     pending,
   output int                                     checked,
   output logic [4:0]                             codes_seen,
   output bpfm_pkg::cfg_type                      thresholds
);

   import bpfm_pkg::*;

   // one predicted response
   typedef struct packed {
      fault_type                    fault;
      logic                         relay;
      logic        [TapWidth-1:0]   cell1;
      logic signed [CellWidth-1:0]  cell2;
      logic signed [CellWidth-1:0]  cell3;
      logic signed [CellWidth-1:0]  cell4;
   } pack_status_type;

   pack_status_type status_q[$];
   fault_type       held_fault;

   // derive cells, apply trips by priority, then the release of the held fault
   function automatic pack_status_type assess_pack(
      input logic [TapWidth-1:0]         tap1, tap2, tap3, tap4, offset,
      input logic signed [MeasWidth-1:0] current, temp
   );
      int              volts [NumCells];
      int              amps, centi;
      int              uvt, uvr, ovt, ovr, oct, ocr, ott, otr;
      logic            any_uv, any_ov, all_above_uvr, all_below_ovr;
      pack_status_type status;
      uvt = int'(thresholds.uv_trip);
      uvr = int'(thresholds.uv_release);
      ovt = int'(thresholds.ov_trip);
      ovr = int'(thresholds.ov_release);
      oct = int'(thresholds.oc_trip);
      ocr = int'(thresholds.oc_release);
      ott = int'($signed(thresholds.ot_trip));
      otr = int'($signed(thresholds.ot_release));
      amps  = int'(current);
      centi = int'(temp);
      volts[0] = int'(tap1) - int'(offset);
      if (volts[0] < 0) volts[0] = 0;
      volts[1] = int'(tap2) - int'(tap1);
      volts[2] = int'(tap3) - int'(tap2);
      volts[3] = int'(tap4) - int'(tap3);

      any_uv = 1'b0;
      any_ov = 1'b0;
      all_above_uvr = 1'b1;
      all_below_ovr = 1'b1;
      for (int i = 0; i < NumCells; i++) begin
         if (volts[i] < uvt) any_uv = 1'b1;
         if (volts[i] > ovt) any_ov = 1'b1;
         if (!(volts[i] > uvr)) all_above_uvr = 1'b0;
         if (!(volts[i] < ovr)) all_below_ovr = 1'b0;
      end

      // any trip replaces whatever is held
      if (any_uv) held_fault = FAULT_UV;
      else if (any_ov) held_fault = FAULT_OV;
      else if (amps > oct || amps < -oct) held_fault = FAULT_OC;
      else if (centi > ott) held_fault = FAULT_OT;

      // release checked on the same measurement
      case (held_fault)
         FAULT_UV: begin
            if (all_above_uvr) held_fault = FAULT_NONE;
         end
         FAULT_OV: begin
            if (all_below_ovr) held_fault = FAULT_NONE;
         end
         FAULT_OC: begin
            if (amps > -ocr && amps < ocr) held_fault = FAULT_NONE;
         end
         FAULT_OT: begin
            if (centi < otr) held_fault = FAULT_NONE;
         end
         default: begin
         end
      endcase

      status.fault = held_fault;
      status.relay = (held_fault == FAULT_NONE);
      status.cell1 = volts[0][TapWidth-1:0];
      status.cell2 = volts[1][CellWidth-1:0];
      status.cell3 = volts[2][CellWidth-1:0];
      status.cell4 = volts[3][CellWidth-1:0];
      return status;
   endfunction

   task automatic report(input string msg);
      $display("%0t ns: response %0d: %s", $time, checked, msg);
      errors++;
   endtask

   // watch all three ports at the clock edge
   always @(posedge clock) begin
      pack_status_type want;
      if (reset) begin
         thresholds = CfgReset;
         held_fault = FAULT_NONE;
         status_q.delete();
         errors     = 0;
         checked    = 0;
         codes_seen = '0;
      end else begin
         // threshold writes
         if (csr_we) begin
            case (csr_index)
               CSR_UV_TRIP:    thresholds.uv_trip    = csr_wdata[TapWidth-1:0];
               CSR_UV_RELEASE: thresholds.uv_release = csr_wdata[TapWidth-1:0];
               CSR_OV_TRIP:    thresholds.ov_trip    = csr_wdata[TapWidth-1:0];
               CSR_OV_RELEASE: thresholds.ov_release = csr_wdata[TapWidth-1:0];
               CSR_OC_TRIP:    thresholds.oc_trip    = csr_wdata[TapWidth-1:0];
               CSR_OC_RELEASE: thresholds.oc_release = csr_wdata[TapWidth-1:0];
               CSR_OT_TRIP:    thresholds.ot_trip    = csr_wdata;
               CSR_OT_RELEASE: thresholds.ot_release = csr_wdata;
               default: begin
               end
            endcase
         end

         // response transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               report("response with nothing outstanding");
            end else begin
               want = status_q.pop_front();
               codes_seen[want.fault] = 1'b1;
               if (rsp_fault !== want.fault)
                  report($sformatf("fault got %0d expected %0d",
                                   rsp_fault, want.fault));
               if (rsp_relay_closed !== want.relay)
                  report($sformatf("relay_closed got %0d expected %0d",
                                   rsp_relay_closed, want.relay));
               if (rsp_cell1_mv !== want.cell1)
                  report($sformatf("cell1_mv got %0d expected %0d",
                                   rsp_cell1_mv, want.cell1));
               if (rsp_cell2_mv !== want.cell2)
                  report($sformatf("cell2_mv got %0d expected %0d",
                                   rsp_cell2_mv, want.cell2));
               if (rsp_cell3_mv !== want.cell3)
                  report($sformatf("cell3_mv got %0d expected %0d",
                                   rsp_cell3_mv, want.cell3));
               if (rsp_cell4_mv !== want.cell4)
                  report($sformatf("cell4_mv got %0d expected %0d",
                                   rsp_cell4_mv, want.cell4));
            end
            checked++;
         end

         // measurement transaction
         if (req_valid && !req_stall)
            status_q.push_back(assess_pack(req_tap1_mv, req_tap2_mv, req_tap3_mv,
                                           req_tap4_mv, req_cell1_offset_mv,
                                           req_current_ma, req_temp_centi));
      end
      pending = status_q.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the battery pack fault monitor. Directed measurements walk each
// fault through trip, hold and release, then random measurements shaped around
// the active thresholds run under several threshold settings, all but one with
// random gaps on both channels. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb;

   import bpfm_pkg::*;

   localparam int CycleLimit = 200000;

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [CsrIdxW-1:0]            csr_index;
   logic [CsrWidth-1:0]           csr_wdata;
   logic                          req_valid;
   logic                          req_stall;
   logic [TapWidth-1:0]           req_tap1_mv, req_tap2_mv, req_tap3_mv, req_tap4_mv;
   logic [TapWidth-1:0]           req_cell1_offset_mv;
   logic signed [MeasWidth-1:0]   req_current_ma, req_temp_centi;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [2:0]                    rsp_fault;
   logic                          rsp_relay_closed;
   logic [TapWidth-1:0]           rsp_cell1_mv;
   logic signed [CellWidth-1:0]   rsp_cell2_mv, rsp_cell3_mv, rsp_cell4_mv;

   int                            errors, pending, checked;
   logic [4:0]                    codes_seen;
   cfg_type                       thresholds;
   cfg_type                       plan;
   logic                          gaps_on = 1'b1;
   int                            items_sent = 0;
   int                            settings_run = 1;
   int                            cycle_count = 0;

   battery_pack_fault_monitor dut (.*);

   bpfm_checker u_checker (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, pending);
         $display("** battery_pack_fault_monitor: FAILED **");
         $finish;
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (gaps_on) rsp_stall <= ($urandom_range(99) < 36);
      else rsp_stall <= 1'b0;
   end

   // one measurement transaction, returns at the edge that accepts it
   task automatic send_item(input logic [TapWidth-1:0] t1, t2, t3, t4, off,
                            input logic signed [MeasWidth-1:0] amps, centi);
      logic fire;
      if (gaps_on && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
      req_tap1_mv         <= t1;
      req_tap2_mv         <= t2;
      req_tap3_mv         <= t3;
      req_tap4_mv         <= t4;
      req_cell1_offset_mv <= off;
      req_current_ma      <= amps;
      req_temp_centi      <= centi;
      req_valid           <= 1'b1;
      do begin
         @(negedge clock);
         fire = !req_stall;
         @(posedge clock);
      end while (!fire);
      items_sent++;
   endtask

   function automatic logic [TapWidth-1:0] to_tap(input int v);
      if (v < 0) return '0;
      if (v > 32767) return '1;
      return v[TapWidth-1:0];
   endfunction

   // measurement given as cell voltages; taps stack up from the offset
   task automatic send_cells(input int c1, c2, c3, c4, off, amps, centi);
      int t1, t2, t3, t4;
      t1 = c1 + off;
      t2 = int'(to_tap(t1)) + c2;
      t3 = int'(to_tap(t2)) + c3;
      t4 = int'(to_tap(t3)) + c4;
      send_item(to_tap(t1), to_tap(t2), to_tap(t3), to_tap(t4), off[TapWidth-1:0],
                amps[MeasWidth-1:0], centi[MeasWidth-1:0]);
   endtask

   // wait until every outstanding response has been taken and checked
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_limits(input cfg_type v);
      write_csr(CSR_UV_TRIP,    {1'b0, v.uv_trip});
      write_csr(CSR_UV_RELEASE, {1'b0, v.uv_release});
      write_csr(CSR_OV_TRIP,    {1'b0, v.ov_trip});
      write_csr(CSR_OV_RELEASE, {1'b0, v.ov_release});
      write_csr(CSR_OC_TRIP,    {1'b0, v.oc_trip});
      write_csr(CSR_OC_RELEASE, {1'b0, v.oc_release});
      write_csr(CSR_OT_TRIP,    v.ot_trip);
      write_csr(CSR_OT_RELEASE, v.ot_release);
      csr_we <= 1'b0;
      settings_run++;
   endtask

   // every register gets sixteen random bits, unused upper bits included
   task automatic scramble_limits();
      csr_index_type idx;
      idx = idx.first();
      do begin
         write_csr(idx, CsrWidth'($urandom_range(65535)));
         idx = idx.next();
      end while (idx != idx.first());
      csr_we <= 1'b0;
      settings_run++;
   endtask

   function automatic int near(input int level, input int spread);
      return level - spread + int'($urandom_range(2 * spread));
   endfunction

   function automatic int full16();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   // cell voltage: mostly healthy, often around a threshold, sometimes anything
   function automatic int pick_volts();
      int r, lo, hi;
      r  = $urandom_range(99);
      lo = int'(thresholds.uv_release);
      hi = int'(thresholds.ov_release);
      if (r < 55) begin
         if (hi > lo + 2) return $urandom_range(hi - 1, lo + 1);
         return near(lo, 200);
      end
      if (r < 70) return near($urandom_range(1) ? int'(thresholds.uv_trip) : lo, 40);
      if (r < 85) return near($urandom_range(1) ? int'(thresholds.ov_trip) : hi, 40);
      return full16();
   endfunction

   function automatic int pick_amps();
      int r, sign;
      r    = $urandom_range(99);
      sign = $urandom_range(1) ? 1 : -1;
      if (r < 40) return near(0, int'(thresholds.oc_release));
      if (r < 60) return sign * near(int'(thresholds.oc_trip), 30);
      if (r < 80) return sign * near(int'(thresholds.oc_release), 30);
      return full16();
   endfunction

   function automatic int pick_temp();
      int r;
      r = $urandom_range(99);
      if (r < 35) return near(int'($signed(thresholds.ot_release)), 1500);
      if (r < 55) return near(int'($signed(thresholds.ot_trip)), 30);
      if (r < 75) return near(int'($signed(thresholds.ot_release)), 30);
      return full16();
   endfunction

   task automatic run_random(input int count);
      repeat (count) begin
         if ($urandom_range(99) < 10)
            send_item(TapWidth'($urandom_range(32767)), TapWidth'($urandom_range(32767)),
                      TapWidth'($urandom_range(32767)), TapWidth'($urandom_range(32767)),
                      TapWidth'($urandom_range(32767)),
                      MeasWidth'(full16()), MeasWidth'(full16()));
         else
            send_cells(pick_volts(), pick_volts(), pick_volts(), pick_volts(),
                       ($urandom_range(99) < 75) ? $urandom_range(40)
                                                 : $urandom_range(32767),
                       pick_amps(), pick_temp());
      end
      drain();
   endtask

   // stimulus
   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_UV_TRIP;
      csr_wdata           = '0;
      req_valid           = 1'b0;
      req_tap1_mv         = '0;
      req_tap2_mv         = '0;
      req_tap3_mv         = '0;
      req_tap4_mv         = '0;
      req_cell1_offset_mv = '0;
      req_current_ma      = '0;
      req_temp_centi      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, reset thresholds: each fault tripped, held in its band, released
      send_cells(3700, 3700, 3700, 3700, 0, 0, 2500);
      send_cells(2900, 3700, 3700, 3700, 0, 0, 2500);
      send_cells(3020, 3020, 3020, 3020, 0, 0, 2500);
      send_cells(3100, 3100, 3100, 3100, 0, 0, 2500);
      send_cells(3700, 3700, 4300, 3700, 0, 0, 2500);
      send_cells(4200, 4200, 4200, 4200, 0, 0, 2500);
      send_cells(4100, 4100, 4100, 4100, 0, 0, 2500);
      send_cells(3700, 3700, 3700, 3700, 0, 15001, 2500);
      send_cells(3700, 3700, 3700, 3700, 0, 5000, 2500);
      send_cells(3700, 3700, 3700, 3700, 0, -1999, 2500);
      send_cells(3700, 3700, 3700, 3700, 0, -15001, 2500);
      send_cells(3700, 3700, 3700, 3700, 0, -2000, 2500);
      send_cells(3700, 3700, 3700, 3700, 0, 0, 2500);
      send_cells(3700, 3700, 3700, 3700, 0, 0, 5501);
      send_cells(3700, 3700, 3700, 3700, 0, 0, 4500);
      send_cells(3700, 3700, 3700, 3700, 0, 0, 4499);
      // lower priority trip replaces a held undervoltage, then overtemp replaces it
      send_cells(3700, 2999, 3700, 3700, 0, 0, 2500);
      send_cells(3020, 3020, 3020, 3020, 0, 20000, 2500);
      send_cells(3700, 3700, 3700, 3700, 0, 0, 6000);
      // all trips at once, priority decides
      send_cells(100, 5000, 3700, 3700, 0, 20000, 9000);
      // field extremes, clamped cell 1, negative and full-scale cells
      send_item('0, '0, '0, '0, '0, 16'sh8000, 16'sh8000);
      send_item('1, '0, '1, '0, '1, 16'sh7fff, 16'sh7fff);
      send_item(15'd100, '1, '1, '1, '1, 16'sh0000, 16'sh0000);
      send_cells(3700, 3700, 3700, 3700, 25, 0, 2500);
      run_random(90);

      // realistic random thresholds, no idling on either side
      gaps_on             <= 1'b0;
      plan.uv_trip        = 15'(2500 + $urandom_range(600));
      plan.uv_release     = plan.uv_trip + 15'($urandom_range(150));
      plan.ov_trip        = 15'(4000 + $urandom_range(400));
      plan.ov_release     = plan.ov_trip - 15'($urandom_range(200));
      plan.oc_trip        = 15'(5000 + $urandom_range(20000));
      plan.oc_release     = 15'($urandom_range(4000));
      plan.ot_trip        = 16'(3000 + $urandom_range(4000));
      plan.ot_release     = plan.ot_trip - 16'($urandom_range(2000));
      load_limits(plan);
      run_random(90);
      gaps_on <= 1'b1;

      // all thresholds at zero
      plan = '0;
      load_limits(plan);
      run_random(90);

      // all thresholds at their tops, overtemp release at the bottom
      plan            = '1;
      plan.ot_trip    = 16'sh7fff;
      plan.ot_release = 16'sh8000;
      load_limits(plan);
      run_random(90);

      // releases set against trips, so trip and release can land together
      plan.uv_trip    = 15'd3300;
      plan.uv_release = 15'd3200;
      plan.ov_trip    = 15'd4000;
      plan.ov_release = 15'd4100;
      plan.oc_trip    = 15'd1000;
      plan.oc_release = 15'd3000;
      plan.ot_trip    = 16'sd2000;
      plan.ot_release = 16'sd4000;
      load_limits(plan);
      run_random(90);

      // fully random thresholds
      repeat (3) begin
         scramble_limits();
         run_random(90);
      end

      $display("summary: %0d measurement sets sent, %0d responses checked,",
               items_sent, checked);
      $display("summary: %0d threshold settings, fault codes reached (ot oc ov uv ok) = %b",
               settings_run, codes_seen);
      if (errors == 0 && pending == 0)
         $display("** battery_pack_fault_monitor: PASSED **");
      else
         $display("** battery_pack_fault_monitor: FAILED **");
      $finish;
   end

endmodule
